// File: sv/lamp_frame_builder_stuffed_assert.svh
// Assertion macros for the lamp frame builder.
// Included by the top level, which checks its own control logic.
`ifndef LAMP_FRAME_BUILDER_STUFFED_ASSERT_SVH
`define LAMP_FRAME_BUILDER_STUFFED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lamp frame builder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lamp frame builder: next-cycle check failed");

`endif

// File: sv/lfbs_pkg.sv
// Shared types and constants of the lamp frame builder.
// Used by the configuration register file and the top level; no dependencies.
package lfbs_pkg;

    localparam int LAMP_W     = 15;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int DATA_FIRST = 5;
    localparam int DATA_BYTES = 4;
    localparam int DATA_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_NUM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 3'd5;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd255;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd253;

    typedef struct packed {
        logic [LAMP_W-1:0] right_lamps;
        logic [LAMP_W-1:0] left_lamps;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } t_out;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] sequence_number;
        logic [BYTE_W-1:0] data_count;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] escape_byte;
    } t_cfg;

endpackage

// File: sv/lamp_frame_builder_stuffed.sv
// Lamp frame builder top level: input buffer, frame serializer and output register.
// Depends on lfbs_pkg, lfbs_cfg_regs and lamp_frame_builder_stuffed_assert.svh.
//
// Each accepted word (right and left lamp maps) becomes one command frame sent one
// byte per output word: FRAME_LENGTH bytes plus one extra byte for each of the four
// lamp data bytes that matches the start or escape byte, so 16 to 20 bytes per
// frame at the default length. The serializer emits one byte per cycle, which sets
// the rate while i_ready does not stall the output; a one-word input buffer takes
// the next word while a frame is still going out, so frames follow each other with
// no gap. An accepted word passes from the input buffer to the serializer, whose bytes
// go to the output register. The checksum byte carries last_byte and is never stuffed.
`include "lamp_frame_builder_stuffed_assert.svh"

module lamp_frame_builder_stuffed #(
    parameter int FRAME_LENGTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  lfbs_pkg::t_in                     i_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output lfbs_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lfbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfbs_pkg::BYTE_W-1:0]       i_cfg_data
);

    localparam int POS_W = $clog2(FRAME_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] DATA_LO    = POS_W'(lfbs_pkg::DATA_FIRST);
    localparam logic [POS_W-1:0] DATA_HI    = POS_W'(lfbs_pkg::DATA_FIRST
                                                     + lfbs_pkg::DATA_BYTES - 1);

    lfbs_pkg::t_cfg cfg;

    lfbs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic                                r_in_valid;
    lfbs_pkg::t_in                       r_in;
    logic                                r_act_valid;
    logic [lfbs_pkg::BYTE_W-1:0]         r_data [lfbs_pkg::DATA_BYTES];
    logic [lfbs_pkg::BYTE_W-1:0]         r_sum;
    logic [POS_W-1:0]                    r_pos;
    logic                                r_esc_half;
    logic                                r_out_valid;
    lfbs_pkg::t_out                      r_out;

    logic                                out_adv;
    logic                                emit;
    logic                                frame_done;
    logic                                load;
    logic [lfbs_pkg::BYTE_W*2-1:0]       right_word;
    logic [lfbs_pkg::BYTE_W*2-1:0]       left_word;
    logic [lfbs_pkg::BYTE_W-1:0]         new_data [lfbs_pkg::DATA_BYTES];
    logic [lfbs_pkg::BYTE_W-1:0]         new_sum;
    logic [POS_W-1:0]                    data_off;
    logic [lfbs_pkg::DATA_IDX_W-1:0]     data_idx;
    logic [lfbs_pkg::BYTE_W-1:0]         cur_data;
    logic                                is_data;
    logic                                needs_esc;
    lfbs_pkg::t_out                      n_out;
    logic                                n_esc_half;
    logic                                step;

    assign out_adv    = !r_out_valid || i_ready;
    assign emit       = r_act_valid && out_adv;
    assign frame_done = emit && (r_pos == LAST_POS);
    assign load       = r_in_valid && (!r_act_valid || frame_done);

    assign o_ready = !r_in_valid || load;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    assign right_word  = {r_in.right_lamps, 1'b0};
    assign left_word   = {r_in.left_lamps, 1'b0};
    assign new_data[0] = right_word[7:0];
    assign new_data[1] = right_word[15:8];
    assign new_data[2] = left_word[7:0];
    assign new_data[3] = left_word[15:8];
    assign new_sum = cfg.device_address + cfg.sequence_number + cfg.data_count
                   + cfg.command_code + new_data[0] + new_data[1]
                   + new_data[2] + new_data[3];

    assign data_off  = r_pos - DATA_LO;
    assign data_idx  = data_off[lfbs_pkg::DATA_IDX_W-1:0];
    assign cur_data  = r_data[data_idx];
    assign is_data   = (r_pos >= DATA_LO) && (r_pos <= DATA_HI);
    assign needs_esc = (cur_data == cfg.escape_byte) || (cur_data == cfg.start_byte);

    always_comb begin
        n_out.frame_byte = '0;
        n_out.last_byte  = 1'b0;
        n_esc_half       = 1'b0;
        step             = 1'b1;
        if (r_pos == '0) begin
            n_out.frame_byte = cfg.start_byte;
        end else if (r_pos == POS_W'(1)) begin
            n_out.frame_byte = cfg.device_address;
        end else if (r_pos == POS_W'(2)) begin
            n_out.frame_byte = cfg.sequence_number;
        end else if (r_pos == POS_W'(3)) begin
            n_out.frame_byte = cfg.data_count;
        end else if (r_pos == POS_W'(4)) begin
            n_out.frame_byte = cfg.command_code;
        end else if (is_data) begin
            if (r_esc_half) begin
                n_out.frame_byte = cur_data - 8'd1;
            end else if (needs_esc) begin
                n_out.frame_byte = cfg.escape_byte;
                n_esc_half       = 1'b1;
                step             = 1'b0;
            end else begin
                n_out.frame_byte = cur_data;
            end
        end else if (r_pos == LAST_POS) begin
            n_out.frame_byte = r_sum;
            n_out.last_byte  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_act_valid <= 1'b0;
            r_pos       <= '0;
            r_esc_half  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_act_valid <= 1'b1;
            end else if (frame_done) begin
                r_act_valid <= 1'b0;
            end
            if (emit) begin
                r_esc_half <= n_esc_half;
                if (frame_done) begin
                    r_pos <= '0;
                end else if (step) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (out_adv) begin
                r_out_valid <= r_act_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        if (load) begin
            r_data <= new_data;
            r_sum  <= new_sum;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    `LFBS_ASSERT_IMPL(a_half_in_data, i_clk, i_rst_n, r_esc_half,
                      r_act_valid && is_data)
    `LFBS_ASSERT_IMPL(a_idle_pos_clear, i_clk, i_rst_n, !r_act_valid,
                      (r_pos == '0) && !r_esc_half)
    `LFBS_ASSERT_IMPL(a_full_buffer, i_clk, i_rst_n, !o_ready, r_in_valid && r_act_valid)
    `LFBS_ASSERT_IMPL(a_escape_sent, i_clk, i_rst_n, $rose(r_esc_half),
                      o_valid && (o_out.frame_byte == cfg.escape_byte) && !o_out.last_byte)
    `LFBS_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, frame_done,
                      (r_pos == '0) && o_valid && o_out.last_byte)

endmodule

// File: sv/lfbs_cfg_regs.sv
// Configuration register file of the lamp frame builder.
// Depends on lfbs_pkg for the register indexes, reset values and the t_cfg type.
module lfbs_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lfbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfbs_pkg::BYTE_W-1:0]       i_cfg_data,
    output lfbs_pkg::t_cfg                    o_cfg
);

    lfbs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte      <= lfbs_pkg::START_BYTE_RST;
            r_cfg.device_address  <= '0;
            r_cfg.sequence_number <= '0;
            r_cfg.data_count      <= '0;
            r_cfg.command_code    <= '0;
            r_cfg.escape_byte     <= lfbs_pkg::ESCAPE_BYTE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfbs_pkg::CFG_START_BYTE: begin
                    r_cfg.start_byte <= i_cfg_data;
                end
                lfbs_pkg::CFG_DEV_ADDR: begin
                    r_cfg.device_address <= i_cfg_data;
                end
                lfbs_pkg::CFG_SEQ_NUM: begin
                    r_cfg.sequence_number <= i_cfg_data;
                end
                lfbs_pkg::CFG_DATA_COUNT: begin
                    r_cfg.data_count <= i_cfg_data;
                end
                lfbs_pkg::CFG_CMD_CODE: begin
                    r_cfg.command_code <= i_cfg_data;
                end
                lfbs_pkg::CFG_ESCAPE_BYTE: begin
                    r_cfg.escape_byte <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule
